// ===== rtl/core/color_space_converter_macros.svh =====
// assertion macros for the color space converter
// expects clk_i and rst_ni in the scope of use
`ifndef COLOR_SPACE_CONVERTER_MACROS_SVH
`define COLOR_SPACE_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csc assertion failed");
`define CSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("csc assertion failed");
`else
`define CSC_ASSERT(lbl, prop)
`define CSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/csc_pkg.sv =====
// shared types, constants and helpers of the color space converter
// no dependencies
`default_nettype none
package csc_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CW        = FRAC_BITS + 1;
  localparam int unsigned NUM_UNITS = 4;
  localparam int unsigned HUE_DW    = FRAC_BITS + 3;

  typedef logic [CW-1:0] chan_t;

  localparam chan_t          ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam chan_t          HALF   = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic [CW:0]    ONE_X2 = {1'b1, {CW{1'b0}}};

  localparam logic [1:0] SPACE_RGB = 2'd0;
  localparam logic [1:0] SPACE_HSL = 2'd1;
  localparam logic [1:0] SPACE_HSV = 2'd2;

  localparam logic [1:0] CFG_IDX_SRC = 2'd0;
  localparam logic [1:0] CFG_IDX_TGT = 2'd1;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    chan_t c2;
  } pix_t;

  typedef struct packed {
    logic [NUM_UNITS-1:0] step_en;
  } ctl_t;

  function automatic chan_t clamp_one(input logic [CW:0] v);
    if (v > {1'b0, ONE}) begin
      return ONE;
    end
    return v[CW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/csc_if.sv =====
// stream and configuration interfaces of the color space converter
// depends on csc_pkg
`default_nettype none
interface csc_in_if import csc_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t chan_first;
  chan_t chan_second;
  chan_t chan_third;
  modport source(output valid, output chan_first, output chan_second, output chan_third,
                 input ready);
  modport sink(input valid, input chan_first, input chan_second, input chan_third,
               output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t res_first;
  chan_t res_second;
  chan_t res_third;
  modport source(output valid, output res_first, output res_second, output res_third,
                 input ready);
  modport sink(input valid, input res_first, input res_second, input res_third,
               output ready);
endinterface

interface csc_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/csc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
// carries a sideband word along; no package dependency
`default_nettype none
module csc_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned DW    = 13,
  parameter int unsigned QW    = 13,
  parameter int unsigned SW    = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic [LANES-1:0][QW+DW-1:0]     num_i,
  input  logic [LANES-1:0][DW-1:0]        den_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][QW-1:0]        quot_o,
  output logic [SW-1:0]                   side_o
);

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                           input logic bit_in,
                                           input logic [DW-1:0] den);
    logic [DW:0] t;
    logic [DW:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, diff[DW-1:0]};
    end
    return {1'b0, t[DW-1:0]};
  endfunction

  logic                            valid_q [QW];
  logic [LANES-1:0][QW-1:0]        lq_q    [QW];
  logic [SW-1:0]                   side_q  [QW];
  logic [LANES-1:0][DW-1:0]        rem_q   [QW-1];
  logic [LANES-1:0][DW-1:0]        den_q   [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     v_in;
    logic [LANES-1:0][DW-1:0] rem_in;
    logic [LANES-1:0][DW-1:0] den_in;
    logic [LANES-1:0][QW-1:0] lq_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][DW-1:0] rem_d;
    logic [LANES-1:0][QW-1:0] lq_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_split
        // upper part is already below the divisor
        assign rem_in[l] = num_i[l][QW+DW-1:QW];
        assign lq_in[l]  = num_i[l][QW-1:0];
      end
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lq_in   = lq_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] st;
      assign st       = div_step(rem_in[l], lq_in[l][QW-1], den_in[l]);
      assign rem_d[l] = st[DW-1:0];
      assign lq_d[l]  = {lq_in[l][QW-2:0], st[DW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        lq_q[k]   <= lq_d;
        side_q[k] <= side_in;
      end
    end

    if (k < QW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = lq_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
`default_nettype wire

// ===== rtl/core/csc_rgb2hsl.sv =====
// rgb to hsl step: extrema, hue numerator, then hue and saturation division
// depends on csc_pkg and csc_div
`default_nettype none
module csc_rgb2hsl import csc_pkg::*; #(
  parameter int unsigned UNIT = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  pix_t  pix_i,
  input  ctl_t  ctl_i,
  output logic  valid_o,
  output pix_t  pix_o,
  output ctl_t  ctl_o
);

  typedef struct packed {
    pix_t  orig;
    ctl_t  ctl;
    chan_t lum;
    logic  dz;
    logic  denz;
  } sb_t;

  localparam int unsigned SW = $bits(sb_t);

  chan_t mx, mn;

  always_comb begin
    mx = pix_i.c0;
    if (pix_i.c1 > mx) mx = pix_i.c1;
    if (pix_i.c2 > mx) mx = pix_i.c2;
    mn = pix_i.c0;
    if (pix_i.c1 < mn) mn = pix_i.c1;
    if (pix_i.c2 < mn) mn = pix_i.c2;
  end

  logic  s1_valid_q;
  pix_t  s1_pix_q;
  ctl_t  s1_ctl_q;
  chan_t s1_mx_q, s1_mn_q;
  logic  s1_isr_q, s1_isg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pix_q <= pix_i;
      s1_ctl_q <= ctl_i;
      s1_mx_q  <= mx;
      s1_mn_q  <= mn;
      s1_isr_q <= (mx == pix_i.c0);
      s1_isg_q <= (mx == pix_i.c1);
    end
  end

  chan_t             delta;
  logic [CW:0]       sum;
  logic [HUE_DW-1:0] d15, d6, num;
  logic [CW:0]       den_w;

  always_comb begin
    delta = s1_mx_q - s1_mn_q;
    sum   = {1'b0, s1_mx_q} + {1'b0, s1_mn_q};
    d15   = {2'b00, delta};
    d6    = (d15 << 2) + (d15 << 1);
    if (s1_isr_q) begin
      if (s1_pix_q.c1 >= s1_pix_q.c2) begin
        num = {2'b00, s1_pix_q.c1 - s1_pix_q.c2};
      end else begin
        num = d6 - {2'b00, s1_pix_q.c2 - s1_pix_q.c1};
      end
    end else if (s1_isg_q) begin
      num = {2'b00, s1_pix_q.c2} + (d15 << 1) - {2'b00, s1_pix_q.c0};
    end else begin
      num = {2'b00, s1_pix_q.c0} + (d15 << 2) - {2'b00, s1_pix_q.c1};
    end
    den_w = (sum > {1'b0, ONE}) ? (ONE_X2 - sum) : sum;
  end

  logic              s2_valid_q;
  logic [HUE_DW-1:0] s2_num_q, s2_d6_q;
  chan_t             s2_delta_q, s2_den_q;
  sb_t               s2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_num_q     <= num;
      s2_d6_q      <= d6;
      s2_delta_q   <= delta;
      s2_den_q     <= den_w[CW-1:0];
      s2_sb_q.orig <= s1_pix_q;
      s2_sb_q.ctl  <= s1_ctl_q;
      s2_sb_q.lum  <= sum[CW:1];
      s2_sb_q.dz   <= (delta == '0);
      s2_sb_q.denz <= (den_w == '0);
    end
  end

  logic [1:0][CW+HUE_DW-1:0] div_num;
  logic [1:0][HUE_DW-1:0]    div_den;
  logic [1:0][CW-1:0]        quot;
  logic [SW-1:0]             side_out;
  logic                      div_valid;
  sb_t                       sb;

  assign div_num[0] = {1'b0, s2_num_q, {FRAC_BITS{1'b0}}};
  assign div_den[0] = s2_d6_q;
  assign div_num[1] = {3'b000, s2_delta_q, {FRAC_BITS{1'b0}}};
  assign div_den[1] = {2'b00, s2_den_q};

  csc_div #(
    .LANES(2),
    .DW   (HUE_DW),
    .QW   (CW),
    .SW   (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_i),
    .valid_i(s2_valid_q),
    .num_i  (div_num),
    .den_i  (div_den),
    .side_i (s2_sb_q),
    .valid_o(div_valid),
    .quot_o (quot),
    .side_o (side_out)
  );

  chan_t hue, sat;

  always_comb begin
    sb  = sb_t'(side_out);
    hue = sb.dz ? '0 : quot[0];
    if (sb.dz) begin
      sat = '0;
    end else if (sb.denz) begin
      sat = ONE;
    end else begin
      sat = clamp_one({1'b0, quot[1]});
    end
    if (sb.ctl.step_en[UNIT]) begin
      pix_o = '{c0: hue, c1: sat, c2: sb.lum};
    end else begin
      pix_o = sb.orig;
    end
  end

  assign valid_o = div_valid;
  assign ctl_o   = sb.ctl;

endmodule
`default_nettype wire

// ===== rtl/core/csc_hsl2hsv.sv =====
// hsl to hsv step: chroma product, value sum, then saturation division
// depends on csc_pkg and csc_div
`default_nettype none
module csc_hsl2hsv import csc_pkg::*; #(
  parameter int unsigned UNIT = 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  pix_t  pix_i,
  input  ctl_t  ctl_i,
  output logic  valid_o,
  output pix_t  pix_o,
  output ctl_t  ctl_o
);

  typedef struct packed {
    pix_t  orig;
    ctl_t  ctl;
    chan_t val;
    logic  black;
    logic  vz;
  } sb_t;

  localparam int unsigned SW = $bits(sb_t);

  logic [FRAC_BITS-1:0]    t;
  logic [2*FRAC_BITS:0]    prod;

  always_comb begin
    // distance of lightness from the nearer end
    if (pix_i.c2 <= HALF) begin
      t = pix_i.c2[FRAC_BITS-1:0];
    end else begin
      t = FRAC_BITS'(ONE - pix_i.c2);
    end
    prod = pix_i.c1 * t;
  end

  logic                 s1_valid_q;
  pix_t                 s1_pix_q;
  ctl_t                 s1_ctl_q;
  logic [FRAC_BITS-1:0] s1_p_q;
  logic                 s1_black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pix_q   <= pix_i;
      s1_ctl_q   <= ctl_i;
      s1_p_q     <= prod[2*FRAC_BITS-1:FRAC_BITS];
      s1_black_q <= (pix_i.c1 == '0) && (pix_i.c2 == '0);
    end
  end

  logic [CW:0] v_sum;
  assign v_sum = {1'b0, s1_pix_q.c2} + {2'b00, s1_p_q};

  logic                 s2_valid_q;
  logic [FRAC_BITS-1:0] s2_p_q;
  chan_t                s2_v_q;
  sb_t                  s2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_p_q        <= s1_p_q;
      s2_v_q        <= clamp_one(v_sum);
      s2_sb_q.orig  <= s1_pix_q;
      s2_sb_q.ctl   <= s1_ctl_q;
      s2_sb_q.val   <= clamp_one(v_sum);
      s2_sb_q.black <= s1_black_q;
      s2_sb_q.vz    <= (v_sum == '0);
    end
  end

  logic [0:0][2*CW-1:0] div_num;
  logic [0:0][CW-1:0]   div_den;
  logic [0:0][CW-1:0]   quot;
  logic [SW-1:0]        side_out;
  logic                 div_valid;
  sb_t                  sb;
  chan_t                sat;

  // 2*p scaled by one
  assign div_num[0] = {1'b0, s2_p_q, {CW{1'b0}}};
  assign div_den[0] = s2_v_q;

  csc_div #(
    .LANES(1),
    .DW   (CW),
    .QW   (CW),
    .SW   (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_i),
    .valid_i(s2_valid_q),
    .num_i  (div_num),
    .den_i  (div_den),
    .side_i (s2_sb_q),
    .valid_o(div_valid),
    .quot_o (quot),
    .side_o (side_out)
  );

  always_comb begin
    sb  = sb_t'(side_out);
    sat = sb.vz ? '0 : clamp_one({1'b0, quot[0]});
    if (sb.ctl.step_en[UNIT] && !sb.black) begin
      pix_o = '{c0: sb.orig.c0, c1: sat, c2: sb.val};
    end else begin
      pix_o = sb.orig;
    end
  end

  assign valid_o = div_valid;
  assign ctl_o   = sb.ctl;

endmodule
`default_nettype wire

// ===== rtl/core/csc_hsv2rgb.sv =====
// hsv to rgb step: chroma and sector, second component, channel assembly
// depends on csc_pkg
`default_nettype none
module csc_hsv2rgb import csc_pkg::*; #(
  parameter int unsigned UNIT = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  pix_t  pix_i,
  input  ctl_t  ctl_i,
  output logic  valid_o,
  output pix_t  pix_o,
  output ctl_t  ctl_o
);

  logic [2*CW-1:0]      vs;
  logic [FRAC_BITS+2:0] h6;
  logic [CW:0]          fold;
  chan_t                omd;

  always_comb begin
    vs   = pix_i.c2 * pix_i.c1;
    h6   = ({2'b00, pix_i.c0} << 2) + ({2'b00, pix_i.c0} << 1);
    // one minus distance of the sector fraction from one
    fold = ONE_X2 - {1'b0, h6[FRAC_BITS:0]};
    omd  = (h6[FRAC_BITS:0] >= ONE) ? fold[CW-1:0] : h6[FRAC_BITS:0];
  end

  logic       s1_valid_q;
  pix_t       s1_pix_q;
  ctl_t       s1_ctl_q;
  chan_t      s1_ch_q, s1_omd_q;
  logic [2:0] s1_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pix_q <= pix_i;
      s1_ctl_q <= ctl_i;
      s1_ch_q  <= vs[2*FRAC_BITS:FRAC_BITS];
      s1_omd_q <= omd;
      s1_sec_q <= h6[FRAC_BITS+2:FRAC_BITS];
    end
  end

  logic [2*CW-1:0] xprod;
  assign xprod = s1_ch_q * s1_omd_q;

  logic       s2_valid_q;
  pix_t       s2_pix_q;
  ctl_t       s2_ctl_q;
  chan_t      s2_ch_q, s2_x_q, s2_m_q;
  logic [2:0] s2_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_pix_q <= s1_pix_q;
      s2_ctl_q <= s1_ctl_q;
      s2_ch_q  <= s1_ch_q;
      s2_x_q   <= xprod[2*FRAC_BITS:FRAC_BITS];
      s2_m_q   <= (s1_pix_q.c2 >= s1_ch_q) ? s1_pix_q.c2 - s1_ch_q : '0;
      s2_sec_q <= s1_sec_q;
    end
  end

  chan_t r1, g1, b1;
  pix_t  rgb;

  always_comb begin
    r1 = '0;
    g1 = '0;
    b1 = '0;
    case (s2_sec_q)
      3'd0: begin
        r1 = s2_ch_q;
        g1 = s2_x_q;
      end
      3'd1: begin
        r1 = s2_x_q;
        g1 = s2_ch_q;
      end
      3'd2: begin
        g1 = s2_ch_q;
        b1 = s2_x_q;
      end
      3'd3: begin
        g1 = s2_x_q;
        b1 = s2_ch_q;
      end
      3'd4: begin
        r1 = s2_x_q;
        b1 = s2_ch_q;
      end
      3'd5: begin
        r1 = s2_ch_q;
        b1 = s2_x_q;
      end
      // full turn: grey only
      default: begin
      end
    endcase
    rgb.c0 = clamp_one({1'b0, r1} + {1'b0, s2_m_q});
    rgb.c1 = clamp_one({1'b0, g1} + {1'b0, s2_m_q});
    rgb.c2 = clamp_one({1'b0, b1} + {1'b0, s2_m_q});
  end

  logic s3_valid_q;
  pix_t s3_pix_q;
  ctl_t s3_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_pix_q <= s2_ctl_q.step_en[UNIT] ? rgb : s2_pix_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign pix_o   = s3_pix_q;
  assign ctl_o   = s3_ctl_q;

endmodule
`default_nettype wire

// ===== rtl/core/color_space_converter.sv =====
// a result passes the stage registers of all four steps and then the output register
// throughput: one pixel per cycle; every stage advances together and halts only
// while the output register holds a result that is not taken
// the chain is rgb-hsl, hsl-hsv, hsv-rgb, rgb-hsl; the three 13-stage dividers set the depth
// reset clears all valid bits and both space registers (rgb to rgb); no clearing pass
`default_nettype none
`include "color_space_converter_macros.svh"
module color_space_converter import csc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  csc_cfg_if.sink    cfg_i,
  csc_in_if.sink     pix_i,
  csc_out_if.source  pix_o
);

  logic [1:0] src_q, tgt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SPACE_RGB;
      tgt_q <= SPACE_RGB;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_IDX_SRC: src_q <= cfg_i.data;
        CFG_IDX_TGT: tgt_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  logic       adv;
  logic       out_valid_q;
  pix_t       out_pix_q;
  logic [2:0] diff, nsteps;
  logic       codes_ok;
  ctl_t       in_ctl;
  pix_t       in_pix;

  assign adv         = !out_valid_q || pix_o.ready;
  assign pix_i.ready = adv;

  always_comb begin
    codes_ok = (src_q <= SPACE_HSV) && (tgt_q <= SPACE_HSV);
    diff     = {1'b0, tgt_q} + 3'd3 - {1'b0, src_q};
    nsteps   = (diff >= 3'd3) ? diff - 3'd3 : diff;
    // steps start at the unit of the source space
    for (int u = 0; u < NUM_UNITS; u++) begin
      in_ctl.step_en[u] = codes_ok && (3'(u) >= {1'b0, src_q}) &&
                          (3'(u) < {1'b0, src_q} + nsteps);
    end
    in_pix.c0 = clamp_one({1'b0, pix_i.chan_first});
    in_pix.c1 = clamp_one({1'b0, pix_i.chan_second});
    in_pix.c2 = clamp_one({1'b0, pix_i.chan_third});
  end

  logic v0, v1, v2, v3;
  pix_t p0, p1, p2, p3;
  ctl_t k0, k1, k2, k3;

  csc_rgb2hsl #(.UNIT(0)) u_rgb2hsl_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(pix_i.valid && pix_i.ready),
    .pix_i  (in_pix),
    .ctl_i  (in_ctl),
    .valid_o(v0),
    .pix_o  (p0),
    .ctl_o  (k0)
  );

  csc_hsl2hsv #(.UNIT(1)) u_hsl2hsv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(v0),
    .pix_i  (p0),
    .ctl_i  (k0),
    .valid_o(v1),
    .pix_o  (p1),
    .ctl_o  (k1)
  );

  csc_hsv2rgb #(.UNIT(2)) u_hsv2rgb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(v1),
    .pix_i  (p1),
    .ctl_i  (k1),
    .valid_o(v2),
    .pix_o  (p2),
    .ctl_o  (k2)
  );

  csc_rgb2hsl #(.UNIT(3)) u_rgb2hsl_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(v2),
    .pix_i  (p2),
    .ctl_i  (k2),
    .valid_o(v3),
    .pix_o  (p3),
    .ctl_o  (k3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= p3;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.res_first  = out_pix_q.c0;
  assign pix_o.res_second = out_pix_q.c1;
  assign pix_o.res_third  = out_pix_q.c2;

  `CSC_ASSERT(a_out_range, pix_o.valid |-> (pix_o.res_first <= ONE && pix_o.res_second <= ONE && pix_o.res_third <= ONE))
  `CSC_ASSERT(a_pipe_hold, (v3 && !adv) |=> (v3 && $stable(p3) && $stable(k3)))
  `CSC_ASSERT(a_cfg_src, (cfg_i.valid && cfg_i.ready && cfg_i.index == CFG_IDX_SRC) |=> (src_q == $past(cfg_i.data)))
  `CSC_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !out_valid_q)

endmodule
`default_nettype wire
